### rtl/rde_pkg.sv
`default_nettype none

package rde_pkg;

  localparam int unsigned SYM_BITS   = 8;
  localparam int unsigned SYM_VALUES = 1 << SYM_BITS;
  localparam int unsigned LEN_BITS   = 8;

  localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2D;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_RD_DIG,
    ST_RD_SYM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/rde_div.sv
`default_nettype none

module rde_div #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [WIDTH-1:0]              dividend,
  input  wire logic [rde_pkg::LEN_BITS-1:0]  divisor,
  output rde_pkg::div_stat_t                 stat,
  output logic      [WIDTH-1:0]              quotient,
  output logic      [rde_pkg::LEN_BITS-1:0]  remainder
);

  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam int unsigned DW = rde_pkg::LEN_BITS;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {remainder, quotient[WIDTH-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[WIDTH-2:0], fits};
      remainder <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### rtl/radix_digit_emitter_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// command   in         cmd_valid/cmd_stall  command, symbol_index, symbol_byte, value
// result    out        res_valid/res_stall  out_byte, last
// config    in         cfg_write_enable     cfg_write_data (alphabet length)
//
// A write transaction leaves the sequencer idle. A convert transaction checks the alphabet,
// then runs the shared restoring divider once per digit, handles the sign in its own state,
// then emits each digit, waiting out any stall.
// Reset clears the sequencer, result valid flag, alphabet length and divider control only.
// The command channel stalls while a conversion is in progress.

module radix_digit_emitter_unit #(
  parameter int unsigned MAX_SYMBOLS = 256,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_enable,
  input  wire logic        [rde_pkg::LEN_BITS-1:0] cfg_write_data,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire logic                                command,
  input  wire logic        [rde_pkg::SYM_BITS-1:0] symbol_index,
  input  wire logic        [rde_pkg::SYM_BITS-1:0] symbol_byte,
  input  wire logic signed [VALUE_BITS-1:0]        value,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic             [rde_pkg::SYM_BITS-1:0] out_byte,
  output logic                                     last
);

  localparam int unsigned IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned NW = $clog2(VALUE_BITS + 1);
  localparam int unsigned BW = $clog2(VALUE_BITS);
  localparam int unsigned LW = rde_pkg::LEN_BITS;
  localparam int unsigned SW = rde_pkg::SYM_BITS;

  rde_pkg::state_t    state;
  rde_pkg::state_t    state_next;
  rde_pkg::div_stat_t div_stat;

  logic [LW-1:0]         alphabet_length;
  logic [SW-1:0]         symbol_table [MAX_SYMBOLS];
  logic [LW-1:0]         digit_buffer [VALUE_BITS];
  logic [SW-1:0]         tbl_rdata;
  logic [IW-1:0]         tbl_raddr;
  logic [LW-1:0]         dig_q;
  logic [SW-1:0]         out_data;
  logic [rde_pkg::SYM_VALUES-1:0] seen;
  logic [LW:0]           ck;
  logic                  rd_pend;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] quotient;
  logic [LW-1:0]         remainder;
  logic [NW-1:0]         nd;
  logic [NW-1:0]         nd_m1;

  logic accept;
  logic is_write;
  logic write_ok;
  logic len_ok;
  logic issue;
  logic bad;
  logic out_free;
  logic div_start;
  logic load_out;
  logic load_last;
  logic quot_zero;

  assign accept    = cmd_valid && !cmd_stall;
  assign is_write  = (command == rde_pkg::CMD_WRITE);
  assign write_ok  = ({1'b0, symbol_index} < (LW + 1)'(MAX_SYMBOLS));
  assign len_ok    = (alphabet_length >= LW'(2)) &&
                     ({1'b0, alphabet_length} <= (LW + 1)'(MAX_SYMBOLS));
  assign issue     = (ck < {1'b0, alphabet_length});
  assign bad       = rd_pend && ((tbl_rdata == rde_pkg::CH_PLUS) ||
                     (tbl_rdata == rde_pkg::CH_MINUS) || seen[tbl_rdata]);
  assign out_free  = !res_valid || !res_stall;
  assign quot_zero = (quotient == '0);
  assign nd_m1     = nd - NW'(1);
  assign value_u   = value;

  always_comb begin
    state_next = state;
    case (state)
      rde_pkg::ST_IDLE: begin
        if (accept && !is_write && len_ok) begin
          state_next = rde_pkg::ST_CHECK;
        end
      end
      rde_pkg::ST_CHECK: begin
        if (bad) begin
          state_next = rde_pkg::ST_IDLE;
        end else if (!issue && !rd_pend) begin
          state_next = rde_pkg::ST_DIV_START;
        end
      end
      rde_pkg::ST_DIV_START: begin
        state_next = rde_pkg::ST_DIV_WAIT;
      end
      rde_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = quot_zero ? rde_pkg::ST_SIGN : rde_pkg::ST_DIV_START;
        end
      end
      rde_pkg::ST_SIGN: begin
        if (!neg || out_free) begin
          state_next = rde_pkg::ST_RD_DIG;
        end
      end
      rde_pkg::ST_RD_DIG: begin
        state_next = rde_pkg::ST_RD_SYM;
      end
      rde_pkg::ST_RD_SYM: begin
        state_next = rde_pkg::ST_OUT;
      end
      rde_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = (nd == NW'(1)) ? rde_pkg::ST_IDLE : rde_pkg::ST_RD_DIG;
        end
      end
      default: begin
        state_next = rde_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    load_last = 1'b0;
    out_data  = tbl_rdata;
    tbl_raddr = ck[IW-1:0];
    case (state)
      rde_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
      end
      rde_pkg::ST_DIV_START: begin
        div_start = 1'b1;
      end
      rde_pkg::ST_SIGN: begin
        load_out = neg && out_free;
        out_data = rde_pkg::CH_MINUS;
      end
      rde_pkg::ST_RD_SYM: begin
        tbl_raddr = dig_q[IW-1:0];
      end
      rde_pkg::ST_OUT: begin
        tbl_raddr = dig_q[IW-1:0];
        load_out  = out_free;
        load_last = (nd == NW'(1));
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rde_pkg::ST_IDLE;
      alphabet_length <= '0;
      res_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        alphabet_length <= cfg_write_data;
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_write && write_ok) begin
      symbol_table[symbol_index[IW-1:0]] <= symbol_byte;
    end
    tbl_rdata <= symbol_table[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == rde_pkg::ST_DIV_WAIT && div_stat.done) begin
      digit_buffer[nd[BW-1:0]] <= remainder;
    end
    dig_q <= digit_buffer[nd_m1[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= out_data;
      last     <= load_last;
    end
    if (accept && !is_write) begin
      neg     <= value_u[VALUE_BITS-1];
      mag     <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
      seen    <= '0;
      ck      <= '0;
      rd_pend <= 1'b0;
      nd      <= '0;
    end else begin
      if (state == rde_pkg::ST_CHECK) begin
        rd_pend <= issue;
        if (issue) begin
          ck <= ck + (LW + 1)'(1);
        end
        if (rd_pend) begin
          seen[tbl_rdata] <= 1'b1;
        end
      end
      if (state == rde_pkg::ST_DIV_WAIT && div_stat.done) begin
        mag <= quotient;
        nd  <= nd + NW'(1);
      end
      if (state == rde_pkg::ST_OUT && out_free) begin
        nd <= nd_m1;
      end
    end
  end

  rde_div #(
    .WIDTH (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (alphabet_length),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

endmodule

`default_nettype wire

### sim/digit_stream_checker.sv
`default_nettype none

module digit_stream_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_enable,
  input  wire logic        [rde_pkg::LEN_BITS-1:0] cfg_write_data,
  input  wire logic                                cmd_valid,
  input  wire logic                                cmd_stall,
  input  wire logic                                command,
  input  wire logic        [rde_pkg::SYM_BITS-1:0] symbol_index,
  input  wire logic        [rde_pkg::SYM_BITS-1:0] symbol_byte,
  input  wire logic signed [VALUE_BITS-1:0]        value,
  input  wire logic                                res_valid,
  input  wire logic                                res_stall,
  input  wire logic        [rde_pkg::SYM_BITS-1:0] out_byte,
  input  wire logic                                last,
  output int                                       mismatch_count,
  output int                                       chars_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SYM_BITS   = rde_pkg::SYM_BITS;
  localparam int unsigned SYM_VALUES = rde_pkg::SYM_VALUES;
  localparam int unsigned LEN_BITS   = rde_pkg::LEN_BITS;

  typedef struct packed {
    logic [SYM_BITS-1:0] ch;
    logic                fin;
  } emitted_char_t;

  logic [SYM_BITS-1:0] symbols [SYM_VALUES];
  logic [LEN_BITS-1:0] radix;
  emitted_char_t       pending_chars [$];

  function automatic bit alphabet_valid();
    bit seen [SYM_VALUES];
    if (radix < 2) return 1'b0;
    for (int i = 0; i < int'(radix); i++) begin
      if (symbols[i] == rde_pkg::CH_PLUS || symbols[i] == rde_pkg::CH_MINUS ||
          seen[symbols[i]]) return 1'b0;
      seen[symbols[i]] = 1'b1;
    end
    return 1'b1;
  endfunction

  // The magnitude is one bit wider than the value, so the most negative value
  // negates exactly.
  function automatic void predict_conversion(input logic signed [VALUE_BITS-1:0] v);
    logic [VALUE_BITS:0] mag;
    logic [SYM_BITS-1:0] digits [$];
    if (!alphabet_valid()) return;
    mag = {v[VALUE_BITS-1], v};
    if (v[VALUE_BITS-1]) begin
      mag = -mag;
      pending_chars.push_back('{ch: rde_pkg::CH_MINUS, fin: 1'b0});
    end
    do begin
      digits.push_front(symbols[SYM_BITS'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[k]) begin
      pending_chars.push_back('{ch: digits[k], fin: (k == digits.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    emitted_char_t expected_char;
    if (rst) begin
      radix = '0;
      pending_chars.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: out_byte=%02h last=%0b", out_byte, last);
          end
        end else begin
          expected_char = pending_chars.pop_front();
          if (expected_char.ch !== out_byte || expected_char.fin !== last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp out_byte=%02h last=%0b, got out_byte=%02h last=%0b",
                       expected_char.ch, expected_char.fin, out_byte, last);
            end
          end
        end
      end
      if (cfg_write_enable) radix = cfg_write_data;
      if (cmd_valid && !cmd_stall) begin
        if (command == rde_pkg::CMD_WRITE) begin
          symbols[symbol_index] = symbol_byte;
        end else begin
          predict_conversion(value);
        end
      end
    end
    chars_outstanding = pending_chars.size();
  end

endmodule

`default_nettype wire

### sim/radix_digit_emitter_unit_tb.sv
`default_nettype none

module radix_digit_emitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SYM_BITS   = rde_pkg::SYM_BITS;
  localparam int unsigned SYM_VALUES = rde_pkg::SYM_VALUES;
  localparam int unsigned LEN_BITS   = rde_pkg::LEN_BITS;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS = 360;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write_enable = 1'b0;
  logic [LEN_BITS-1:0] cfg_write_data = '0;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic                command = rde_pkg::CMD_WRITE;
  logic [SYM_BITS-1:0] symbol_index = '0;
  logic [SYM_BITS-1:0] symbol_byte = '0;
  logic signed [31:0]  value = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [SYM_BITS-1:0] out_byte;
  logic                last;
  int                  mismatch_count;
  int                  chars_outstanding;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          item_count = 0;
  int          cycle_count = 0;
  int unsigned cur_length = 0;
  bit          loaded [SYM_VALUES];

  radix_digit_emitter_unit dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .command         (command),
    .symbol_index    (symbol_index),
    .symbol_byte     (symbol_byte),
    .value           (value),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .out_byte        (out_byte),
    .last            (last)
  );

  digit_stream_checker #(.VALUE_BITS(32)) digit_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic apply_mode(input int mode);
    case (mode)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 46;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 46;
      end
      default: begin
        sender_idle_pct = 6;
        receiver_stall_pct = 6;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_command(input logic cmd, input logic [SYM_BITS-1:0] idx,
                              input logic [SYM_BITS-1:0] sym, input logic signed [31:0] val);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    symbol_index <= idx;
    symbol_byte <= sym;
    value <= val;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
    item_count++;
    if (cmd == rde_pkg::CMD_WRITE) loaded[idx] = 1'b1;
  endtask

  task automatic write_symbol(input logic [SYM_BITS-1:0] idx, input logic [SYM_BITS-1:0] sym);
    send_command(rde_pkg::CMD_WRITE, idx, sym, $urandom);
  endtask

  // Every table entry below the current length is written before a conversion.
  task automatic convert(input logic signed [31:0] val);
    for (int i = 0; i < int'(cur_length); i++) begin
      if (!loaded[i]) write_symbol(SYM_BITS'(i), SYM_BITS'($urandom_range(1, 255)));
    end
    send_command(rde_pkg::CMD_CONVERT, SYM_BITS'($urandom), SYM_BITS'($urandom), val);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (chars_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(input int unsigned len);
    drain();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= LEN_BITS'(len);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    cur_length = len;
  endtask

  task automatic load_alphabet(input int unsigned len, input bit broken);
    logic [SYM_BITS-1:0] pool [$];
    logic [SYM_BITS-1:0] tmp;
    int unsigned         j;
    int unsigned         spot;
    for (int v = 1; v < 256; v++) begin
      if (SYM_BITS'(v) != rde_pkg::CH_PLUS && SYM_BITS'(v) != rde_pkg::CH_MINUS) begin
        pool.push_back(SYM_BITS'(v));
      end
    end
    for (int i = pool.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int i = 0; i < int'(len); i++) write_symbol(SYM_BITS'(i), pool[i]);
    if (broken && len >= 2) begin
      spot = $urandom_range(len - 1);
      case ($urandom_range(2))
        0: write_symbol(SYM_BITS'(spot), rde_pkg::CH_PLUS);
        1: write_symbol(SYM_BITS'(spot), rde_pkg::CH_MINUS);
        default: write_symbol(SYM_BITS'(spot), pool[(spot + 1 + $urandom_range(len - 2)) % len]);
      endcase
    end
  endtask

  function automatic int pick_value();
    int m;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(0, 3000);
      5: return -int'($urandom_range(0, 3000));
      6: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 0;
          default: return -1;
        endcase
      end
      7: begin
        m = 1;
        repeat ($urandom_range(1, 6)) m = m * int'(cur_length);
        m = m + int'($urandom_range(0, 2)) - 1;
        return $urandom_range(1) ? -m : m;
      end
      default: begin
        m = int'($urandom >> $urandom_range(31));
        return $urandom_range(1) ? -m : m;
      end
    endcase
  endfunction

  initial begin
    int unsigned r;
    int unsigned len;
    int          phase;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    apply_mode(0);

    set_length(0);
    convert(5);
    write_symbol(8'd0, 8'h30);
    write_symbol(8'd1, 8'h31);
    set_length(1);
    convert(5);
    set_length(2);
    convert(32'sh8000_0000);
    convert(0);
    convert(-1);
    convert(32'sh7FFF_FFFF);
    write_symbol(8'd1, rde_pkg::CH_PLUS);
    convert(7);
    write_symbol(8'd1, rde_pkg::CH_MINUS);
    convert(7);
    write_symbol(8'd1, 8'h30);
    convert(7);
    write_symbol(8'd1, 8'h00);
    convert(6);
    write_symbol(8'd1, 8'h31);
    write_symbol(8'd255, 8'hFF);
    convert(32'sh5555_5555);

    phase = 1;
    apply_mode(phase % 4);
    load_alphabet(253, 1'b0);
    write_symbol(8'd253, rde_pkg::CH_PLUS);
    write_symbol(8'd254, SYM_BITS'($urandom_range(1, 255)));
    set_length(253);
    repeat (8) convert(pick_value());
    set_length(255);
    repeat (4) convert(pick_value());

    while (item_count < RANDOM_ITEMS) begin
      phase++;
      apply_mode(phase % 4);
      r = $urandom_range(99);
      if (r < 5) len = $urandom_range(1);
      else if (r < 60) len = $urandom_range(2, 16);
      else if (r < 85) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 253);
      set_length(len);
      if (len <= 64 && $urandom_range(1) == 1) load_alphabet(len, $urandom_range(99) < 20);
      repeat ($urandom_range(8, 20)) begin
        if ($urandom_range(99) < 80) begin
          convert(pick_value());
        end else if ($urandom_range(9) == 0) begin
          write_symbol(SYM_BITS'($urandom), rde_pkg::CH_MINUS);
        end else begin
          write_symbol(SYM_BITS'($urandom), SYM_BITS'($urandom_range(1, 255)));
        end
      end
    end

    drain();
    if (mismatch_count == 0 && chars_outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
